// ===== rtl/puc_pkg.sv =====
// shared types and constants for the passphrase utf-8 checker
// no dependencies; imported by every module of the block

package puc_pkg;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_DEL     = 8'h7f;
  localparam logic [7:0] BYTE_CONT_LO = 8'h80;
  localparam logic [7:0] BYTE_CONT_HI = 8'hbf;
  localparam logic [7:0] BYTE_MID_LO  = 8'h90;
  localparam logic [7:0] BYTE_UPR_LO  = 8'ha0;
  localparam logic [7:0] BYTE_LEAD2   = 8'hc2;
  localparam logic [7:0] BYTE_LEAD3   = 8'he0;
  localparam logic [7:0] BYTE_SURR    = 8'hed;
  localparam logic [7:0] BYTE_LEAD4   = 8'hf0;
  localparam logic [7:0] BYTE_LEAD4_HI = 8'hf4;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    KIND_NORMAL,  // 80..bf
    KIND_E0,      // a0..bf
    KIND_ED,      // 80..9f
    KIND_F0,      // 90..bf
    KIND_F4       // 80..8f
  } lead_kind_t;

  // per-byte decode
  typedef struct packed {
    logic       control;    // forbidden control byte
    logic       ascii;      // single-byte character
    logic [1:0] due_len;    // continuations a lead asks for, zero if not a lead
    lead_kind_t lead_kind;  // range rule for the first continuation
    logic       cont_lo;    // 80..8f
    logic       cont_mid;   // 90..9f
    logic       cont_hi;    // a0..bf
  } byte_class_t;

  typedef struct packed {
    logic basic;
    logic strict;
  } verdict_t;

endpackage

// ===== rtl/puc_byte_class.sv =====
// byte classifier: control, ascii, lead and continuation ranges
// depends on puc_pkg

module puc_byte_class (
  input  logic [7:0]          data_byte,
  output puc_pkg::byte_class_t cls
);
  import puc_pkg::*;

  always_comb begin
    cls.control  = ((data_byte < BYTE_SPACE) && (data_byte != BYTE_TAB)) ||
                   (data_byte == BYTE_DEL);
    cls.ascii    = (data_byte < BYTE_CONT_LO);
    cls.cont_lo  = (data_byte >= BYTE_CONT_LO) && (data_byte < BYTE_MID_LO);
    cls.cont_mid = (data_byte >= BYTE_MID_LO) && (data_byte < BYTE_UPR_LO);
    cls.cont_hi  = (data_byte >= BYTE_UPR_LO) && (data_byte <= BYTE_CONT_HI);
    cls.due_len   = 2'd0;
    cls.lead_kind = KIND_NORMAL;
    priority if (data_byte >= BYTE_LEAD2 && data_byte < BYTE_LEAD3) begin
      cls.due_len = 2'd1;
    end else if (data_byte >= BYTE_LEAD3 && data_byte < BYTE_LEAD4) begin
      cls.due_len = 2'd2;
      if (data_byte == BYTE_LEAD3) cls.lead_kind = KIND_E0;
      else if (data_byte == BYTE_SURR) cls.lead_kind = KIND_ED;
    end else if (data_byte >= BYTE_LEAD4 && data_byte <= BYTE_LEAD4_HI) begin
      cls.due_len = 2'd3;
      if (data_byte == BYTE_LEAD4) cls.lead_kind = KIND_F0;
      else if (data_byte == BYTE_LEAD4_HI) cls.lead_kind = KIND_F4;
    end else begin
      cls.due_len = 2'd0;
    end
  end

endmodule

// ===== rtl/puc_tracker.sv =====
// string state: saturating counts, control flag and utf-8 decoder state
// depends on puc_pkg; fed by puc_byte_class

module puc_tracker #(
  parameter int MAX_BYTES = 128,
  parameter int MIN_CHARS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 is_end,
  input  puc_pkg::byte_class_t cls,
  output puc_pkg::verdict_t    verdict
);
  import puc_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 2);
  localparam int NW = $clog2(MIN_CHARS + 1);

  logic [CW-1:0] byte_count, byte_count_next;
  logic [NW-1:0] char_count, char_count_next;
  logic          control_seen, control_seen_next;
  logic          utf8_error, utf8_error_next;
  logic [1:0]    continuations_due, continuations_due_next;
  lead_kind_t    lead_kind, lead_kind_next;
  logic          cont_ok;

  always_comb begin
    unique case (lead_kind)
      KIND_NORMAL: cont_ok = cls.cont_lo | cls.cont_mid | cls.cont_hi;
      KIND_E0:     cont_ok = cls.cont_hi;
      KIND_ED:     cont_ok = cls.cont_lo | cls.cont_mid;
      KIND_F0:     cont_ok = cls.cont_mid | cls.cont_hi;
      KIND_F4:     cont_ok = cls.cont_lo;
      default:     cont_ok = 1'b0;
    endcase
  end

  always_comb begin
    logic char_inc;
    char_inc               = 1'b0;
    byte_count_next        = byte_count;
    char_count_next        = char_count;
    control_seen_next      = control_seen;
    utf8_error_next        = utf8_error;
    continuations_due_next = continuations_due;
    lead_kind_next         = lead_kind;
    if (step && is_end) begin
      byte_count_next        = '0;
      char_count_next        = '0;
      control_seen_next      = 1'b0;
      utf8_error_next        = 1'b0;
      continuations_due_next = 2'd0;
      lead_kind_next         = KIND_NORMAL;
    end else if (step) begin
      if (byte_count < CW'(MAX_BYTES + 1)) byte_count_next = byte_count + 1'b1;
      if (cls.control) control_seen_next = 1'b1;
      if (!utf8_error) begin
        if (continuations_due != 2'd0) begin
          lead_kind_next = KIND_NORMAL;
          if (!cont_ok) begin
            utf8_error_next        = 1'b1;
            continuations_due_next = 2'd0;
          end else begin
            continuations_due_next = continuations_due - 2'd1;
            char_inc               = (continuations_due == 2'd1);
          end
        end else if (cls.ascii) begin
          char_inc = 1'b1;
        end else if (cls.due_len != 2'd0) begin
          continuations_due_next = cls.due_len;
          lead_kind_next         = cls.lead_kind;
        end else begin
          utf8_error_next = 1'b1;
        end
      end
      if (char_inc && (char_count < NW'(MIN_CHARS))) char_count_next = char_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      char_count        <= '0;
      control_seen      <= 1'b0;
      utf8_error        <= 1'b0;
      continuations_due <= 2'd0;
      lead_kind         <= KIND_NORMAL;
    end else begin
      byte_count        <= byte_count_next;
      char_count        <= char_count_next;
      control_seen      <= control_seen_next;
      utf8_error        <= utf8_error_next;
      continuations_due <= continuations_due_next;
      lead_kind         <= lead_kind_next;
    end
  end

  always_comb begin
    verdict.basic  = (byte_count != '0) && (byte_count <= CW'(MAX_BYTES)) && !control_seen;
    verdict.strict = verdict.basic && !utf8_error && (continuations_due == 2'd0) &&
                     (char_count >= NW'(MIN_CHARS));
  end

endmodule

// ===== rtl/passphrase_utf8_checker.sv =====
// channel  | signals                              | word
// ---------+--------------------------------------+-----------------------------
// input    | data_valid, data_ready, data_byte    | one passphrase byte, 0 ends
// output   | result_valid, result_ready,          | verdicts, one per string
//          | basic_ok, strict_ok                  |
//
// top level of the passphrase utf-8 checker
// depends on puc_pkg, puc_byte_class, puc_tracker
//
// one byte a cycle while no zero byte is held back: a word goes into the input register,
// then classification and the state update run from that register, so a byte's effect
// lands in the tracker state as the byte leaves the register. a terminating zero loads
// the result register as it leaves the input register, and the verdict is offered from there.
// synchronous reset clears the valid flags and all string state.
// a stalled result holds only a zero byte in the input register; other bytes
// keep flowing while the result waits

module passphrase_utf8_checker #(
  parameter int MAX_BYTES = 128,
  parameter int MIN_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       basic_ok,
  output logic       strict_ok
);
  import puc_pkg::*;

  // input register
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_end;
  logic        hold_go;
  byte_class_t cls;
  verdict_t    verdict;

  assign hold_end = (hold_byte == BYTE_END);
  // a zero byte waits until the result register is free or being emptied
  assign hold_go  = hold_valid && (!hold_end || !result_valid || result_ready);
  assign data_ready = !hold_valid || hold_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (data_ready) begin
      hold_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ready && data_valid) begin
      hold_byte <= data_byte;
    end
  end

  puc_byte_class u_class (
    .data_byte (hold_byte),
    .cls       (cls)
  );

  puc_tracker #(
    .MAX_BYTES (MAX_BYTES),
    .MIN_CHARS (MIN_CHARS)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (hold_go),
    .is_end  (hold_end),
    .cls     (cls),
    .verdict (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (hold_go && hold_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_go && hold_end) begin
      basic_ok  <= verdict.basic;
      strict_ok <= verdict.strict;
    end
  end

`ifndef SYNTHESIS
  // strict verdict always includes the basic one
  a_strict_implies_basic: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!strict_ok || basic_ok))
    else $error("strict_ok without basic_ok");

  // only a terminating zero facing a full, stalled result register may stall
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !hold_go) |-> (hold_end && result_valid && !result_ready))
    else $error("input register stalled without cause");

  // a consumed terminator always produces a result next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (hold_go && hold_end) |=> result_valid)
    else $error("terminator consumed without result");
`endif

endmodule

// ===== tb/puc_verdict_checker.sv =====
// verdict checker for the passphrase utf-8 checker testbench
// depends on puc_pkg; watches both channels, predicts verdicts and compares them

`timescale 1ns / 1ps

module puc_verdict_checker #(
  parameter int MAX_BYTES = 128,
  parameter int MIN_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  input  logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic       basic_ok,
  input  logic       strict_ok,
  output int         fail_count,
  output int         verdicts_pending,
  output int         verdicts_checked
);

  import puc_pkg::*;

  // running state of the string under way
  int         n_bytes;
  int         n_chars;
  logic       ctrl_hit;
  logic       utf8_bad;
  logic [1:0] due;
  lead_kind_t next_kind;

  verdict_t   verdict_q[$];
  verdict_t   want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on verdict %0d: %s", $realtime, verdicts_checked, msg);
    fail_count++;
  endtask

  function automatic void forget_string();
    n_bytes   = 0;
    n_chars   = 0;
    ctrl_hit  = 1'b0;
    utf8_bad  = 1'b0;
    due       = 2'd0;
    next_kind = KIND_NORMAL;
  endfunction

  function automatic void count_char();
    if (n_chars < MIN_CHARS) n_chars++;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    verdict_t   v;
    logic [7:0] lo;
    logic [7:0] hi;
    if (b == BYTE_END) begin
      v.basic  = (n_bytes >= 1) && (n_bytes <= MAX_BYTES) && !ctrl_hit;
      v.strict = v.basic && !utf8_bad && (due == 2'd0) && (n_chars >= MIN_CHARS);
      verdict_q.push_back(v);
      forget_string();
    end else begin
      if (n_bytes < MAX_BYTES + 1) n_bytes++;
      if ((b < BYTE_SPACE && b != BYTE_TAB) || b == BYTE_DEL) ctrl_hit = 1'b1;
      if (!utf8_bad) begin
        if (due != 2'd0) begin
          lo = BYTE_CONT_LO;
          hi = BYTE_CONT_HI;
          case (next_kind)
            KIND_E0: lo = BYTE_UPR_LO;
            KIND_ED: hi = BYTE_UPR_LO - 8'd1;
            KIND_F0: lo = BYTE_MID_LO;
            KIND_F4: hi = BYTE_MID_LO - 8'd1;
            default: ;
          endcase
          if (b < lo || b > hi) begin
            utf8_bad  = 1'b1;
            due       = 2'd0;
            next_kind = KIND_NORMAL;
          end else begin
            next_kind = KIND_NORMAL;
            due       = due - 2'd1;
            if (due == 2'd0) count_char();
          end
        end else if (b < BYTE_CONT_LO) begin
          count_char();
        end else if (b >= BYTE_LEAD2 && b < BYTE_LEAD3) begin
          due       = 2'd1;
          next_kind = KIND_NORMAL;
        end else if (b >= BYTE_LEAD3 && b < BYTE_LEAD4) begin
          due       = 2'd2;
          next_kind = (b == BYTE_LEAD3) ? KIND_E0 :
                      (b == BYTE_SURR)  ? KIND_ED : KIND_NORMAL;
        end else if (b >= BYTE_LEAD4 && b <= BYTE_LEAD4_HI) begin
          due       = 2'd3;
          next_kind = (b == BYTE_LEAD4)    ? KIND_F0 :
                      (b == BYTE_LEAD4_HI) ? KIND_F4 : KIND_NORMAL;
        end else begin
          utf8_bad = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      forget_string();
      verdict_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict basic %0b strict %0b with none due",
                                    basic_ok, strict_ok));
        end else begin
          want = verdict_q.pop_front();
          if (basic_ok !== want.basic)
            report_mismatch($sformatf("basic_ok %0b, predicted %0b", basic_ok, want.basic));
          if (strict_ok !== want.strict)
            report_mismatch($sformatf("strict_ok %0b, predicted %0b", strict_ok, want.strict));
        end
        verdicts_checked++;
      end
      if (data_valid && data_ready) absorb_byte(data_byte);
    end
    verdicts_pending <= verdict_q.size();
  end

endmodule

// ===== tb/tb_passphrase_utf8_checker.sv =====
// testbench top for the passphrase utf-8 checker: stimulus, idling and verdict
// depends on puc_pkg, passphrase_utf8_checker and puc_verdict_checker

`timescale 1ns / 1ps

module tb_passphrase_utf8_checker;

  import puc_pkg::*;

  localparam int MAX_BYTES   = 128;
  localparam int MIN_CHARS   = 8;
  // words for the whole run, directed part included
  localparam int TOTAL_WORDS = 1550;
  // far beyond what a correct run needs
  localparam int CYCLE_LIMIT = 200000;
  // the block answers through its result register after the end byte; leave room for that
  localparam int DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst          = 1'b1;
  logic       data_valid   = 1'b0;
  logic       data_ready;
  logic [7:0] data_byte    = 8'h00;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       basic_ok;
  logic       strict_ok;

  int fail_count;
  int verdicts_pending;
  int verdicts_checked;

  // random gaps on both sides; switched off for one quiet stretch
  logic gaps_on = 1'b1;
  int   cycles  = 0;

  // run statistics for the summary
  int words_sent;
  int strings_sent;
  int long_strings;
  int spoiled_strings;
  int noise_strings;

  // bytes of the passphrase being built, end byte not included
  logic [7:0] str_q[$];

  passphrase_utf8_checker #(
    .MAX_BYTES (MAX_BYTES),
    .MIN_CHARS (MIN_CHARS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .basic_ok     (basic_ok),
    .strict_ok    (strict_ok)
  );

  puc_verdict_checker #(
    .MAX_BYTES (MAX_BYTES),
    .MIN_CHARS (MIN_CHARS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .data_valid       (data_valid),
    .data_ready       (data_ready),
    .data_byte        (data_byte),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .basic_ok         (basic_ok),
    .strict_ok        (strict_ok),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending),
    .verdicts_checked (verdicts_checked)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d verdicts outstanding",
               cycles, verdicts_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure, ready low with odds of about 16 in a hundred while gaps are on
  always @(negedge clk) begin
    if (gaps_on) begin
      result_ready <= ($urandom_range(99) >= 16);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // one word on the input channel; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 16) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    // hold valid and payload until the rising edge that takes the word
    do @(posedge clk); while (!data_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // the built passphrase followed by its end byte
  task automatic send_string();
    foreach (str_q[i]) push_byte(str_q[i]);
    push_byte(BYTE_END);
    strings_sent++;
  endtask

  // one well-formed character, leads biased towards the special second-byte ranges
  function automatic void add_char();
    int         r;
    logic [7:0] lead;
    r = $urandom_range(3);
    case (r)
      0: begin
        // printable ascii or tab
        r = $urandom_range(95);
        str_q.push_back((r == 95) ? BYTE_TAB : BYTE_SPACE + 8'(r));
      end
      1: begin
        str_q.push_back(8'($urandom_range(8'hc2, 8'hdf)));
        str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
      end
      2: begin
        r    = $urandom_range(2);
        lead = (r == 0) ? BYTE_LEAD3 : (r == 1) ? BYTE_SURR :
               8'($urandom_range(BYTE_LEAD3, 8'hef));
        str_q.push_back(lead);
        // first continuation range depends on the lead: no overlong, no surrogates
        if (lead == BYTE_LEAD3)
          str_q.push_back(8'($urandom_range(BYTE_UPR_LO, BYTE_CONT_HI)));
        else if (lead == BYTE_SURR)
          str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_UPR_LO - 1)));
        else
          str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
        str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
      end
      default: begin
        r    = $urandom_range(2);
        lead = (r == 0) ? BYTE_LEAD4 : (r == 1) ? BYTE_LEAD4_HI :
               8'($urandom_range(BYTE_LEAD4, BYTE_LEAD4_HI));
        str_q.push_back(lead);
        // f0 must not be overlong, f4 must stay at or below U+10FFFF
        if (lead == BYTE_LEAD4)
          str_q.push_back(8'($urandom_range(BYTE_MID_LO, BYTE_CONT_HI)));
        else if (lead == BYTE_LEAD4_HI)
          str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_MID_LO - 1)));
        else
          str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
        str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
        str_q.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
      end
    endcase
  endfunction

  // well-formed characters, then ascii padding to land exactly on the length
  function automatic void fill_to(input int target);
    while (str_q.size() < target - 4) add_char();
    while (str_q.size() < target) str_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
  endfunction

  // damage a string: control byte, delete, bad lead, overlong, surrogate,
  // out-of-range four-byte forms, or a sequence cut short at the end
  function automatic void spoil_string();
    int         pos;
    int         n_bad;
    logic [7:0] bad0;
    logic [7:0] bad1;
    n_bad = 1;
    bad1  = BYTE_CONT_LO;
    case ($urandom_range(7))
      0: bad0 = 8'($urandom_range(8'h01, BYTE_SPACE - 1));
      1: bad0 = BYTE_DEL;
      2: begin
        case ($urandom_range(2))
          0:       bad0 = 8'($urandom_range(8'hc0, 8'hc1));
          1:       bad0 = 8'($urandom_range(8'hf5, 8'hff));
          default: bad0 = 8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI));
        endcase
      end
      3: begin
        bad0  = BYTE_LEAD3;
        bad1  = 8'($urandom_range(BYTE_CONT_LO, BYTE_UPR_LO - 1));
        n_bad = 2;
      end
      4: begin
        bad0  = BYTE_SURR;
        bad1  = 8'($urandom_range(BYTE_UPR_LO, BYTE_CONT_HI));
        n_bad = 2;
      end
      5: begin
        bad0  = BYTE_LEAD4;
        bad1  = 8'($urandom_range(BYTE_CONT_LO, BYTE_MID_LO - 1));
        n_bad = 2;
      end
      6: begin
        bad0  = BYTE_LEAD4_HI;
        bad1  = 8'($urandom_range(BYTE_MID_LO, BYTE_CONT_HI));
        n_bad = 2;
      end
      default: begin
        // cut short: a lead with nothing after it
        str_q.push_back(8'($urandom_range(BYTE_LEAD2, BYTE_LEAD4_HI)));
        n_bad = 0;
      end
    endcase
    if (n_bad > 0) begin
      // may land inside a multi-byte character, which is fine
      pos = $urandom_range(str_q.size());
      str_q.insert(pos, bad0);
      if (n_bad == 2) str_q.insert(pos + 1, bad1);
    end
    spoiled_strings++;
  endfunction

  // eight ascii characters, then a tail of up to four bytes
  task automatic send_with_tail(input logic [7:0] t0, input logic [7:0] t1,
                                input logic [7:0] t2, input logic [7:0] t3,
                                input int n_tail);
    str_q.delete();
    for (int i = 0; i < 8; i++) str_q.push_back(8'h61 + 8'(i));
    if (n_tail > 0) str_q.push_back(t0);
    if (n_tail > 1) str_q.push_back(t1);
    if (n_tail > 2) str_q.push_back(t2);
    if (n_tail > 3) str_q.push_back(t3);
    send_string();
  endtask

  initial begin
    int stim_goal;
    int quiet_from;
    int pick;
    int n_chars;

    words_sent      = 0;
    strings_sent    = 0;
    long_strings    = 0;
    spoiled_strings = 0;
    noise_strings   = 0;

    // reset held from the start of the run, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // empty string: the end byte comes first
    str_q.delete();
    send_string();
    // every utf-8 length at its extremes, tab and tilde, eleven characters
    str_q = '{8'h09, 8'h7e, 8'h20, 8'h61, 8'hc2, 8'h80, 8'hdf, 8'hbf,
              8'he0, 8'ha0, 8'h80, 8'hef, 8'hbf, 8'hbf, 8'hed, 8'h9f, 8'hbf,
              8'hf0, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_string();
    // one character short of the minimum
    str_q = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67};
    send_string();
    // forbidden control bytes and delete
    str_q = '{8'h01, 8'hff};
    send_string();
    str_q = '{8'h1f, 8'h41};
    send_string();
    str_q = '{BYTE_DEL};
    send_string();
    // sequence cut short before the end byte
    send_with_tail(8'he2, 8'h82, 8'h00, 8'h00, 2);
    // overlong, surrogate, above the top code point, bad leads, bad continuation
    send_with_tail(8'he0, 8'h9f, 8'hbf, 8'h00, 3);
    send_with_tail(8'hed, 8'ha0, 8'h80, 8'h00, 3);
    send_with_tail(8'hf0, 8'h8f, 8'hbf, 8'hbf, 4);
    send_with_tail(8'hf4, 8'h90, 8'h80, 8'h80, 4);
    send_with_tail(8'hc0, 8'haf, 8'h00, 8'h00, 2);
    send_with_tail(8'hf5, 8'h00, 8'h00, 8'h00, 1);
    send_with_tail(8'h80, 8'h00, 8'h00, 8'h00, 1);
    send_with_tail(8'he2, 8'h41, 8'h00, 8'h00, 2);
    // longest allowed string, then one byte too many
    str_q.delete();
    fill_to(MAX_BYTES);
    send_string();
    str_q.delete();
    fill_to(MAX_BYTES + 1);
    send_string();
    long_strings += 2;

    // ---- random part ----
    stim_goal  = TOTAL_WORDS;
    quiet_from = words_sent + 500;
    while (words_sent < stim_goal) begin
      // one stretch with no gaps on either side
      gaps_on <= !(words_sent >= quiet_from && words_sent < quiet_from + 350);
      str_q.delete();
      pick = $urandom_range(99);
      if (pick < 4) begin
        // empty string
      end else if (pick < 7) begin
        // around the length limit, occasionally far past it
        case ($urandom_range(4))
          0:       fill_to(MAX_BYTES);
          1:       fill_to(MAX_BYTES + 1);
          2:       fill_to(MAX_BYTES - 1);
          3:       fill_to(MAX_BYTES + 2);
          default: fill_to($urandom_range(MAX_BYTES - 8, MAX_BYTES + 40));
        endcase
        long_strings++;
      end else if (pick < 20) begin
        // raw noise, any nonzero byte
        repeat ($urandom_range(1, 20)) str_q.push_back(8'($urandom_range(1, 255)));
        noise_strings++;
      end else begin
        // well-formed content clustered round the minimum character count
        n_chars = ($urandom_range(3) == 0) ? $urandom_range(1, 14) :
                  $urandom_range(MIN_CHARS - 2, MIN_CHARS + 2);
        repeat (n_chars) add_char();
        if (pick < 42) spoil_string();
      end
      send_string();
    end
    data_valid <= 1'b0;
    gaps_on    <= 1'b1;

    // wait for every predicted verdict, then a short quiet spell
    while (verdicts_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d strings in %0d words: %0d near or over the length limit,",
             strings_sent, words_sent, long_strings);
    $display("%0d deliberately damaged, %0d noise; %0d verdicts checked, %0d mismatches",
             spoiled_strings, noise_strings, verdicts_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
